>>> rtl/core/ufa_pkg.sv
package ufa_pkg;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   localparam logic [11:0] IDX_MAX       = 12'hFFF;
   localparam logic [7:0]  EOF_MASK      = 8'h02;
   localparam logic [11:0] MIN_PACKET    = 12'd2;
   localparam logic [7:0]  MIN_HEADER    = 8'd2;
   localparam logic [23:0] CAP_RESET     = 24'd1114112;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  data_byte;
      logic        first_in_packet;
      logic [11:0] packet_length;
      logic        packet_error;
   } req_item_type;

   typedef struct packed {
      logic        kind;
      logic [23:0] write_offset;
      logic [7:0]  payload_byte;
      logic [23:0] frame_length;
      logic [31:0] frame_number;
   } rsp_item_type;

endpackage

>>> rtl/core/ufa_in_stage.sv
module ufa_in_stage
   import ufa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         item_valid,
   input  logic         item_take,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign req_ready  = item_take || !valid_ff;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

>>> rtl/core/ufa_engine.sv
module ufa_engine
   import ufa_pkg::*;
#(
   parameter int POSITION_BITS = 24
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [23:0]  csr_write_data,
   input  logic         item_valid,
   output logic         item_take,
   input  req_item_type item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp
);

   localparam int POS_W = POSITION_BITS + 1;

   logic [23:0]        capacity_ff;
   logic [11:0]        byte_index_ff, byte_index_in;
   logic [7:0]         header_length_ff, header_length_in;
   logic               accepted_ff, accepted_in;
   logic               eof_ff, eof_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   tstart_ff, tstart_in;
   logic [31:0]        frames_ff, frames_in;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_ff;

   logic               advance;
   logic               fire;
   logic               emit;
   rsp_item_type       res;
   logic [31:0]        cap_wide;
   logic [POS_W-1:0]   cap;
   logic [POS_W-1:0]   pos_end;
   logic [POS_W+23:0]  pos_ext;
   logic [POS_W+23:0]  pos_end_ext;
   logic [11:0]        idx_cur;
   logic [7:0]         hlen_cur;
   logic               acc_cur;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign item_take = advance;
   assign fire      = item_valid && advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // capacity masked to the position width
   assign cap_wide    = {8'd0, capacity_ff};
   assign cap         = {1'b0, cap_wide[POSITION_BITS-1:0]};
   // roll back a transfer that overran capacity
   assign pos_end     = (pos_ff > cap) ? tstart_ff : pos_ff;
   assign pos_ext     = {24'd0, pos_ff};
   assign pos_end_ext = {24'd0, pos_end};

   always_comb begin
      byte_index_in    = byte_index_ff;
      header_length_in = header_length_ff;
      accepted_in      = accepted_ff;
      eof_in           = eof_ff;
      pos_in           = pos_ff;
      tstart_in        = tstart_ff;
      frames_in        = frames_ff;
      emit             = 1'b0;
      res              = '0;
      idx_cur          = byte_index_ff;
      hlen_cur         = header_length_ff;
      acc_cur          = accepted_ff;

      if (item.opcode == OP_END) begin
         pos_in = pos_end;
         if (eof_ff && (pos_end != '0)) begin
            frames_in        = frames_ff + 32'd1;
            emit             = 1'b1;
            res.kind         = KIND_FRAME;
            res.frame_length = pos_end_ext[23:0];
            res.frame_number = frames_ff + 32'd1;
            pos_in           = '0;
         end
         tstart_in        = pos_in;
         eof_in           = 1'b0;
         accepted_in      = 1'b0;
         byte_index_in    = '0;
         header_length_in = '0;
      end else begin
         // the first byte decides the whole packet
         if (item.first_in_packet) begin
            idx_cur  = '0;
            hlen_cur = item.data_byte;
            acc_cur  = !item.packet_error && (item.packet_length >= MIN_PACKET) &&
                       (item.data_byte >= MIN_HEADER) &&
                       ({4'd0, item.data_byte} <= item.packet_length);
         end
         header_length_in = hlen_cur;
         accepted_in      = acc_cur;
         byte_index_in    = (idx_cur < IDX_MAX) ? idx_cur + 12'd1 : idx_cur;

         if (acc_cur && (idx_cur < item.packet_length)) begin
            if (idx_cur == 12'd1) begin
               if ((item.data_byte & EOF_MASK) != 8'd0) begin
                  eof_in = 1'b1;
               end
            end else if (idx_cur >= {4'd0, hlen_cur}) begin
               if (pos_ff < cap) begin
                  emit             = 1'b1;
                  res.kind         = KIND_WRITE;
                  res.write_offset = pos_ext[23:0];
                  res.payload_byte = item.data_byte;
               end
               if (pos_ff != '1) begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff    <= '0;
         header_length_ff <= '0;
         accepted_ff      <= 1'b0;
         eof_ff           <= 1'b0;
         pos_ff           <= '0;
         tstart_ff        <= '0;
         frames_ff        <= '0;
      end else if (fire) begin
         byte_index_ff    <= byte_index_in;
         header_length_ff <= header_length_in;
         accepted_ff      <= accepted_in;
         eof_ff           <= eof_in;
         pos_ff           <= pos_in;
         tstart_ff        <= tstart_in;
         frames_ff        <= frames_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fire && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_ff <= res;
      end
   end

`ifndef SYNTH
   a_frame_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.kind == KIND_FRAME)) |-> (rsp_ff.frame_length != 24'd0))
      else $error("frame complete word with zero length");

   a_end_clears_eof: assert property (@(posedge clock) disable iff (reset)
      (fire && (item.opcode == OP_END)) |=> (!eof_ff && !accepted_ff && (byte_index_ff == '0)))
      else $error("end of transfer left packet state behind");

   a_frame_resets_pos: assert property (@(posedge clock) disable iff (reset)
      (fire && emit && (res.kind == KIND_FRAME)) |=> ((pos_ff == '0) && (tstart_ff == '0)))
      else $error("position not cleared after frame complete");

   a_count_only_on_frame: assert property (@(posedge clock) disable iff (reset)
      !(fire && emit && (res.kind == KIND_FRAME)) |=> $stable(frames_ff))
      else $error("frame count moved without a frame complete word");
`endif

endmodule

>>> rtl/core/uvc_payload_frame_assembler.sv
// Channel | Handshake            | Payload
// req     | req_valid/req_ready  | opcode, data_byte, first_in_packet, packet_length,
//         |                      | packet_error
// rsp     | rsp_valid/rsp_ready  | kind, write_offset, payload_byte, frame_length,
//         |                      | frame_number
// csr     | csr_write_enable     | csr_write_data (frame capacity)
//
// One word per cycle sustained while results are taken; an accepted word is held in the
// input register, then the state update feeds its result, if any, into the result register.
// Reset clears all packet, position and frame-count state and sets capacity to 1114112.
// With a result pending and rsp_ready low the result register holds; the input register takes one more
// word, then req_ready drops until the result is taken.
module uvc_payload_frame_assembler
   import ufa_pkg::*;
#(
   parameter int POSITION_BITS = 24
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_in_packet,
   input  logic [11:0] req_packet_length,
   input  logic        req_packet_error,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [23:0] rsp_write_offset,
   output logic [7:0]  rsp_payload_byte,
   output logic [23:0] rsp_frame_length,
   output logic [31:0] rsp_frame_number
);

   req_item_type req_item;
   req_item_type item;
   rsp_item_type rsp;
   logic         item_valid;
   logic         item_take;

   assign req_item.opcode          = req_opcode;
   assign req_item.data_byte       = req_data_byte;
   assign req_item.first_in_packet = req_first_in_packet;
   assign req_item.packet_length   = req_packet_length;
   assign req_item.packet_error    = req_packet_error;

   assign rsp_kind         = rsp.kind;
   assign rsp_write_offset = rsp.write_offset;
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_frame_length = rsp.frame_length;
   assign rsp_frame_number = rsp.frame_number;

   ufa_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   ufa_engine #(
      .POSITION_BITS (POSITION_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item_take        (item_take),
      .item             (item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp)
   );

endmodule
